// ----- sv/resolver_speed_estimator_core_macros.svh -----
// Assertion macros shared by the resolver speed estimator modules.
`ifndef RESOLVER_SPEED_ESTIMATOR_CORE_MACROS_SVH
`define RESOLVER_SPEED_ESTIMATOR_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define RSEC_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define RSEC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rsec_pkg.sv -----
// Shared types and constants of the resolver speed estimator.
package rsec_pkg;

   // Field widths
   localparam int ANGLE_W = 16;
   localparam int TOP_W   = 8;
   localparam int SUM_W   = 25;
   localparam int DIFF_W  = 18;
   localparam int ACC_W   = SUM_W + 1;

   // Averaging window
   localparam int WINDOW_TAPS = 10;
   localparam int PTR_W       = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
   localparam int TOTAL_W     = SUM_W + $clog2(WINDOW_TAPS);
   localparam int MAG_W       = TOTAL_W;
   localparam int RECIP_SHIFT = MAG_W + $clog2(WINDOW_TAPS);
   localparam int RECIP_W     = MAG_W + 1;
   localparam int PROD_W      = MAG_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_TAPS) - 64'd1) / 64'(WINDOW_TAPS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   // Queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = FIFO_AW + 1;

   // Stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEC_TOP   = 2'd2;

   localparam logic [ANGLE_W-1:0] WRAP_LOW_RST  = 16'd4000;
   localparam logic [ANGLE_W-1:0] WRAP_HIGH_RST = 16'd60000;
   localparam logic [TOP_W-1:0]   DEC_TOP_RST   = 8'd20;

   localparam logic signed [DIFF_W-1:0] FULL_TURN = 18'sd65536;
   localparam logic signed [SUM_W-1:0]  SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic [ANGLE_W-1:0] wrap_low;
      logic [ANGLE_W-1:0] wrap_high;
      logic [TOP_W-1:0]   dec_top;
   } rsec_cfg_type;

endpackage

// ----- sv/resolver_speed_estimator_core.sv -----
// Throughput: one angle sample per cycle; req stalls only when the four-entry queue fills.
// The back pipeline (window update, magnitude, reciprocal multiply, output) runs one sum a cycle unless rsp stalls.
// Reset (synchronous, active high) loads default thresholds and top, clears the window,
// the running sum, the accumulator, the counter and the previous angle.
module resolver_speed_estimator_core
   import rsec_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // [15:0] angle_sample
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [24:0] average_displacement, [31:25] zero
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   rsec_cfg_type            cfg_ff;
   logic                    push_valid, push_ready;
   logic signed [SUM_W-1:0] push_data;
   logic                    pop_valid, pop_ready;
   logic signed [SUM_W-1:0] pop_data;

   assign csr_ready = 1'b1;

   // Configuration registers; unknown indexes drop the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrap_low  <= WRAP_LOW_RST;
         cfg_ff.wrap_high <= WRAP_HIGH_RST;
         cfg_ff.dec_top   <= DEC_TOP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WRAP_LOW:  cfg_ff.wrap_low  <= csr_data[ANGLE_W-1:0];
            CSR_WRAP_HIGH: cfg_ff.wrap_high <= csr_data[ANGLE_W-1:0];
            CSR_DEC_TOP:   cfg_ff.dec_top   <= csr_data[TOP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rsec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rsec_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rsec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- sv/rsec_front.sv -----
// Front end: unwraps angle samples, accumulates displacement, decimates.
module rsec_front
   import rsec_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  rsec_cfg_type             cfg,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_W-1:0]    req_tdata,
   output logic                     push_valid,
   input  logic                     push_ready,
   output logic signed [SUM_W-1:0]  push_data
);

   logic [ANGLE_W-1:0]        prev_ff, prev_in;
   logic [TOP_W-1:0]          cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [ANGLE_W-1:0]        cur;
   logic                      wrap_fwd, wrap_bwd, accept, at_top;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [ACC_W-1:0]   acc;
   logic signed [SUM_W-1:0]   acc_sat;

   assign req_tready = push_ready;
   assign accept     = req_tvalid & req_tready;
   assign at_top     = (cnt_ff == cfg.dec_top);
   assign push_valid = accept & at_top;
   assign push_data  = acc_sat;

   // Unwrap the current sample against the previous one and form the step
   always_comb begin
      cur      = req_tdata[ANGLE_W-1:0];
      wrap_fwd = (cur < cfg.wrap_low) && (prev_ff > cfg.wrap_high);
      wrap_bwd = (cur > cfg.wrap_high) && (prev_ff < cfg.wrap_low);
      diff     = $signed(DIFF_W'({2'b00, cur})) - $signed(DIFF_W'({2'b00, prev_ff}));
      if (wrap_fwd) begin
         diff = diff + FULL_TURN;
      end else if (wrap_bwd) begin
         diff = diff - FULL_TURN;
      end
   end

   // Accumulate with saturation
   always_comb begin
      acc = {sum_ff[SUM_W-1], sum_ff} + {{(ACC_W-DIFF_W){diff[DIFF_W-1]}}, diff};
      if (acc[ACC_W-1] != acc[ACC_W-2]) begin
         acc_sat = acc[ACC_W-1] ? SUM_MIN : SUM_MAX;
      end else begin
         acc_sat = acc[SUM_W-1:0];
      end
   end

   // Advance counter; clear the sum on a decimation beat
   always_comb begin
      prev_in = prev_ff;
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      if (accept) begin
         prev_in = cur;
         if (at_top) begin
            cnt_in = '0;
            sum_in = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            sum_in = acc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
      end else begin
         prev_ff <= prev_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

// ----- sv/rsec_fifo.sv -----
// Short queue of decimated sums between front and back.
module rsec_fifo
   import rsec_pkg::*;
`include "resolver_speed_estimator_core_macros.svh"
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  logic signed [SUM_W-1:0]  push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output logic signed [SUM_W-1:0]  pop_data
);

   logic signed [SUM_W-1:0] mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]      count_ff, count_in;
   logic                    push, pop;

   assign push_ready = (count_ff != FIFO_CW'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // Move pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store an entry on each push beat
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RSEC_ASSERT(a_fifo_count_bound, count_ff <= FIFO_CW'(FIFO_DEPTH), "queue overfilled")
   `RSEC_ASSERT_NEXT(a_fifo_push, push && !pop, count_ff == $past(count_ff) + 1'b1, "push lost")

endmodule

// ----- sv/rsec_back.sv -----
// Back end: window update, running sum and divide by the window length.
module rsec_back
   import rsec_pkg::*;
`include "resolver_speed_estimator_core_macros.svh"
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  logic signed [SUM_W-1:0]  pop_data,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_W-1:0]    rsp_tdata
);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_TAPS - 1);

   logic signed [SUM_W-1:0]   win_ff [WINDOW_TAPS];
   logic [PTR_W-1:0]          win_ptr_ff, win_ptr_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic                      s1_valid_ff;
   logic                      s2_valid_ff;
   logic [MAG_W-1:0]          mag_ff;
   logic                      s2_neg_ff;
   logic                      s3_valid_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic                      s3_neg_ff;
   logic                      out_valid_ff;
   logic signed [SUM_W-1:0]   avg_ff, avg_in;
   logic                      out_ready, s3_ready, s2_ready, s1_ready, pop;
   logic signed [SUM_W-1:0]   old_entry;
   logic [SUM_W-1:0]          quot;

   // Stage handshakes: each stage moves when the next has room
   assign out_ready = !out_valid_ff || rsp_tready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign pop_ready = s1_ready;
   assign pop       = pop_valid & s1_ready;

   // Replace the oldest window entry in the running total
   always_comb begin
      old_entry  = win_ff[win_ptr_ff];
      total_in   = total_ff
                 + {{(TOTAL_W-SUM_W){pop_data[SUM_W-1]}}, pop_data}
                 - {{(TOTAL_W-SUM_W){old_entry[SUM_W-1]}}, old_entry};
      win_ptr_in = (win_ptr_ff == PTR_LAST) ? '0 : win_ptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_TAPS; i++) begin
            win_ff[i] <= '0;
         end
         win_ptr_ff <= '0;
         total_ff   <= '0;
      end else if (pop) begin
         win_ff[win_ptr_ff] <= pop_data;
         win_ptr_ff         <= win_ptr_in;
         total_ff           <= total_in;
      end
   end

   // Round quotient toward zero and negate back
   always_comb begin
      quot   = prod_ff[RECIP_SHIFT +: SUM_W];
      avg_in = s3_neg_ff ? -$signed(quot) : $signed(quot);
   end

   // Pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= pop;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Pipeline payload: magnitude, reciprocal product, result
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_neg_ff <= total_ff[TOTAL_W-1];
         mag_ff    <= total_ff[TOTAL_W-1] ? MAG_W'(-total_ff) : MAG_W'(total_ff);
      end
      if (s2_valid_ff && s3_ready) begin
         s3_neg_ff <= s2_neg_ff;
         prod_ff   <= PROD_W'(mag_ff) * PROD_W'(RECIP);
      end
      if (s3_valid_ff && out_ready) begin
         avg_ff <= avg_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-SUM_W){1'b0}}, avg_ff};

   `RSEC_ASSERT(a_back_ptr_range, win_ptr_ff <= PTR_LAST, "window pointer out of range")
   `RSEC_ASSERT_NEXT(a_back_pop_stage, pop, s1_valid_ff, "popped sum did not enter the pipeline")

endmodule
